FILE: sv/gbn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gbn_pkg;

    localparam int MAX_OUT = 64;
    localparam int CNT_W   = 7;
    localparam logic [1:0] DUP_LIMIT = 2'd3;

    typedef enum logic [1:0] {
        OP_MSG  = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_WINDOW  = 2'd0,
        CFG_TIMEOUT = 2'd1,
        CFG_TOTAL   = 2'd2
    } cfg_index_t;

    typedef enum logic {
        FE_IDLE,
        FE_EXEC
    } fe_state_t;

    // one run of packets for the back end
    typedef struct packed {
        logic [31:0]      seq;
        logic [CNT_W-1:0] count;
        logic             resend;
    } job_t;

    function automatic logic [31:0] signed_byte_sum(input logic [63:0] w, input int nbytes);
        logic [31:0] s;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < nbytes) begin
                s = s + {{24{w[8*i+7]}}, w[8*i +: 8]};
            end
        end
        return s;
    endfunction

    function automatic logic [63:0] narrow_payload(input logic [63:0] w, input int nbytes);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < nbytes) begin
                r[8*i +: 8] = w[8*i +: 8];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/gbn_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module gbn_queue
    import gbn_pkg::*;
#(
    parameter int DW = 48
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire logic [DW-1:0] din,
    output logic               full,
    input  wire logic          pop,
    output logic [DW-1:0]      dout,
    output logic               valid
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [DW-1:0] fifo_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full  = (count_reg == (PW+1)'(DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (PW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

FILE: sv/gbn_front.sv
`timescale 1ns / 1ps
`default_nettype none
module gbn_front
    import gbn_pkg::*;
#(
    parameter int BUFFER_DEPTH  = 64,
    parameter int PAYLOAD_BYTES = 8,
    parameter int AW            = 6
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [159:0]  s_tdata,
    input  wire logic [1:0]    s_tuser,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_addr,
    input  wire logic [31:0]   cfg_wdata,
    input  wire logic          back_idle,
    input  wire logic          q_full,
    output logic               q_push,
    output job_t               q_job,
    output logic [AW-1:0]      q_slot,
    output logic               mem_we,
    output logic [AW-1:0]      mem_slot,
    output logic [63:0]        mem_wdata
);

    localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam logic [31:0]   DEPTH32 = 32'(BUFFER_DEPTH);
    localparam logic [SW-1:0] DEPTH_S = SW'(BUFFER_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(BUFFER_DEPTH - 1);

    fe_state_t state_reg, state_next;

    logic [1:0]  op_reg;
    logic [31:0] ack_reg;
    logic        chk_ok_reg;
    logic [63:0] data_reg;

    logic [6:0]  win_reg;
    logic [15:0] tmo_reg;
    logic [31:0] total_reg;

    logic [31:0]   base_reg, base_next;
    logic [31:0]   nts_reg, nts_next;
    logic [31:0]   nf_reg, nf_next;
    logic [1:0]    dup_reg, dup_next;
    logic          tmr_on_reg, tmr_on_next;
    logic [15:0]   tmr_left_reg, tmr_left_next;
    logic [AW-1:0] base_slot_reg, base_slot_next;
    logic [AW-1:0] nts_slot_reg, nts_slot_next;
    logic [AW-1:0] nf_slot_reg, nf_slot_next;

    logic [6:0]    w_eff;
    logic [31:0]   inflight, ack_ofs, base_eff, nf_eff, pend_inflight, pend_avail;
    logic [6:0]    resend_cnt, pend_room, pend_cnt;
    logic          can_store;
    logic [SW-1:0] nts_slot_sum, base_slot_sum;
    logic [AW-1:0] nts_slot_adv, base_slot_adv, nf_slot_inc;
    logic          push_c, we_c, stall, commit;
    logic [31:0]   calc;

    assign s_tready = (state_reg == FE_IDLE);

    // checksum of an arriving ACK is settled in the accept cycle
    assign calc = s_tdata[31:0] + s_tdata[63:32]
                + signed_byte_sum(s_tdata[159:96], PAYLOAD_BYTES);

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg     <= s_tuser;
            ack_reg    <= s_tdata[63:32];
            chk_ok_reg <= (calc == s_tdata[95:64]);
            data_reg   <= narrow_payload(s_tdata[159:96], PAYLOAD_BYTES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= 7'd8;
            tmo_reg   <= 16'd15;
            total_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_WINDOW:  win_reg   <= cfg_wdata[6:0];
                CFG_TIMEOUT: tmo_reg   <= cfg_wdata[15:0];
                CFG_TOTAL:   total_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff = (win_reg == '0) ? 7'd1 : ((win_reg > 7'(MAX_OUT)) ? 7'(MAX_OUT) : win_reg);
        inflight   = nts_reg - base_reg;
        ack_ofs    = ack_reg - base_reg;
        resend_cnt = (inflight > 32'(MAX_OUT)) ? 7'(MAX_OUT) : inflight[6:0];
        can_store  = ((nf_reg - base_reg) < DEPTH32);

        base_eff      = (op_reg == OP_ACK) ? ack_reg + 32'd1 : base_reg;
        nf_eff        = (op_reg == OP_MSG) ? nf_reg + 32'd1 : nf_reg;
        pend_inflight = nts_reg - base_eff;
        pend_avail    = nf_eff - nts_reg;
        pend_room     = (pend_inflight < {25'd0, w_eff}) ? w_eff - pend_inflight[6:0] : 7'd0;
        pend_cnt      = (pend_avail < {25'd0, pend_room}) ? pend_avail[6:0] : pend_room;

        nts_slot_sum  = SW'(nts_slot_reg) + SW'(pend_cnt);
        nts_slot_adv  = (nts_slot_sum >= DEPTH_S) ? AW'(nts_slot_sum - DEPTH_S)
                                                  : AW'(nts_slot_sum);
        base_slot_sum = SW'(base_slot_reg) + SW'(ack_ofs[6:0]) + SW'(1);
        base_slot_adv = (base_slot_sum >= DEPTH_S) ? AW'(base_slot_sum - DEPTH_S)
                                                   : AW'(base_slot_sum);
        nf_slot_inc   = (nf_slot_reg == LAST_SLOT) ? '0 : nf_slot_reg + AW'(1);
    end

    always_comb begin
        state_next     = state_reg;
        base_next      = base_reg;
        nts_next       = nts_reg;
        nf_next        = nf_reg;
        dup_next       = dup_reg;
        tmr_on_next    = tmr_on_reg;
        tmr_left_next  = tmr_left_reg;
        base_slot_next = base_slot_reg;
        nts_slot_next  = nts_slot_reg;
        nf_slot_next   = nf_slot_reg;
        push_c         = 1'b0;
        we_c           = 1'b0;
        stall          = 1'b0;
        q_job          = '0;
        q_slot         = '0;

        unique case (state_reg)
            FE_IDLE: begin
                if (s_tvalid) begin
                    state_next = FE_EXEC;
                end
            end
            FE_EXEC: begin
                unique case (op_reg)
                    OP_MSG: begin
                        if (can_store) begin
                            // payload store is shared with runs still being read
                            stall        = !back_idle;
                            we_c         = 1'b1;
                            nf_next      = nf_reg + 32'd1;
                            nf_slot_next = nf_slot_inc;
                            if (pend_cnt != '0) begin
                                push_c        = 1'b1;
                                q_job         = '{seq: nts_reg, count: pend_cnt, resend: 1'b0};
                                q_slot        = nts_slot_reg;
                                nts_next      = nts_reg + {25'd0, pend_cnt};
                                nts_slot_next = nts_slot_adv;
                                if (pend_inflight == '0 && !tmr_on_reg) begin
                                    tmr_on_next   = 1'b1;
                                    tmr_left_next = tmo_reg;
                                end
                            end
                        end
                    end
                    OP_ACK: begin
                        if (chk_ok_reg) begin
                            if (ack_ofs[31]) begin
                                if (base_reg != total_reg) begin
                                    if (dup_reg == DUP_LIMIT) begin
                                        dup_next = 2'd1;
                                        if (resend_cnt != '0) begin
                                            push_c = 1'b1;
                                            q_job  = '{seq: base_reg, count: resend_cnt,
                                                       resend: 1'b1};
                                            q_slot = base_slot_reg;
                                        end
                                    end else begin
                                        dup_next = dup_reg + 2'd1;
                                    end
                                end
                            end else if (ack_ofs < inflight) begin
                                base_next      = base_eff;
                                base_slot_next = base_slot_adv;
                                tmr_on_next    = 1'b0;
                                if (base_eff == nts_reg) begin
                                    if (pend_cnt != '0) begin
                                        push_c        = 1'b1;
                                        q_job         = '{seq: nts_reg, count: pend_cnt,
                                                          resend: 1'b0};
                                        q_slot        = nts_slot_reg;
                                        nts_next      = nts_reg + {25'd0, pend_cnt};
                                        nts_slot_next = nts_slot_adv;
                                        tmr_on_next   = 1'b1;
                                        tmr_left_next = tmo_reg;
                                    end
                                end else begin
                                    tmr_on_next   = 1'b1;
                                    tmr_left_next = tmo_reg;
                                end
                            end
                        end
                    end
                    OP_TICK: begin
                        if (tmr_on_reg) begin
                            if (tmr_left_reg <= 16'd1) begin
                                tmr_left_next = tmo_reg;
                                if (resend_cnt != '0) begin
                                    push_c = 1'b1;
                                    q_job  = '{seq: base_reg, count: resend_cnt, resend: 1'b1};
                                    q_slot = base_slot_reg;
                                end
                            end else begin
                                tmr_left_next = tmr_left_reg - 16'd1;
                            end
                        end
                    end
                    default: ;
                endcase
                if (push_c && q_full) begin
                    stall = 1'b1;
                end
                if (!stall) begin
                    state_next = FE_IDLE;
                end
            end
            default: state_next = FE_IDLE;
        endcase
    end

    assign commit    = (state_reg == FE_EXEC) && !stall;
    assign q_push    = push_c && commit;
    assign mem_we    = we_c && commit;
    assign mem_slot  = nf_slot_reg;
    assign mem_wdata = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            nts_reg       <= '0;
            nf_reg        <= '0;
            dup_reg       <= '0;
            tmr_on_reg    <= 1'b0;
            tmr_left_reg  <= '0;
            base_slot_reg <= '0;
            nts_slot_reg  <= '0;
            nf_slot_reg   <= '0;
        end else if (commit) begin
            base_reg      <= base_next;
            nts_reg       <= nts_next;
            nf_reg        <= nf_next;
            dup_reg       <= dup_next;
            tmr_on_reg    <= tmr_on_next;
            tmr_left_reg  <= tmr_left_next;
            base_slot_reg <= base_slot_next;
            nts_slot_reg  <= nts_slot_next;
            nf_slot_reg   <= nf_slot_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/gbn_back.sv
`timescale 1ns / 1ps
`default_nettype none
module gbn_back
    import gbn_pkg::*;
#(
    parameter int BUFFER_DEPTH  = 64,
    parameter int PAYLOAD_BYTES = 8,
    parameter int AW            = 6
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    input  wire job_t          q_job,
    input  wire logic [AW-1:0] q_slot,
    output logic               q_pop,
    input  wire logic          mem_we,
    input  wire logic [AW-1:0] mem_slot,
    input  wire logic [63:0]   mem_wdata,
    output logic               back_idle,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [127:0]       m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    localparam logic [AW-1:0] LAST_SLOT = AW'(BUFFER_DEPTH - 1);

    logic [63:0] mem [BUFFER_DEPTH];

    logic             act_reg;
    logic [31:0]      seq_reg;
    logic [AW-1:0]    slot_reg;
    logic [CNT_W-1:0] left_reg;
    logic             rs_reg;

    logic        b_valid_reg;
    logic [31:0] b_seq_reg;
    logic        b_rs_reg;
    logic        b_last_reg;
    logic [63:0] rd_data_reg;

    logic         o_valid_reg;
    logic [127:0] o_data_reg;
    logic         o_user_reg;
    logic         o_last_reg;

    logic o_free, b_adv, b_free, issue, last_issue;

    assign o_free     = !o_valid_reg || m_tready;
    assign b_adv      = b_valid_reg && o_free;
    assign b_free     = !b_valid_reg || b_adv;
    assign issue      = act_reg && b_free;
    assign last_issue = (left_reg == CNT_W'(1));
    assign q_pop      = !act_reg && q_valid;
    assign back_idle  = !act_reg && !q_valid;

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = o_user_reg;
    assign m_tlast  = o_last_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_slot] <= mem_wdata;
        end
        if (issue) begin
            rd_data_reg <= mem[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg     <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                act_reg <= 1'b1;
            end else if (issue && last_issue) begin
                act_reg <= 1'b0;
            end
            if (issue) begin
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv) begin
                o_valid_reg <= 1'b1;
            end else if (m_tready) begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            seq_reg  <= q_job.seq;
            slot_reg <= q_slot;
            left_reg <= q_job.count;
            rs_reg   <= q_job.resend;
        end else if (issue) begin
            seq_reg  <= seq_reg + 32'd1;
            slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + AW'(1);
            left_reg <= left_reg - CNT_W'(1);
        end
        if (issue) begin
            b_seq_reg  <= seq_reg;
            b_rs_reg   <= rs_reg;
            b_last_reg <= last_issue;
        end
        if (b_adv) begin
            o_data_reg <= {rd_data_reg,
                           b_seq_reg + signed_byte_sum(rd_data_reg, PAYLOAD_BYTES),
                           b_seq_reg};
            o_user_reg <= b_rs_reg;
            o_last_reg <= b_last_reg;
        end
    end

endmodule
`default_nettype wire

FILE: sv/go_back_n_sender_core.sv
// Go-Back-N sender. In the front end, the idle state accepts each input item (message,
// ACK or timer tick) and checks the ACK checksum; the exec state then updates the
// window and timer and queues a run of packets. A message that is stored waits in the
// exec state until the back end has finished reading earlier runs, since both use the
// payload memory. The back end emits one packet per cycle from a run while the output
// is ready, after loading the run from the four-entry queue into its run registers; the
// first packet of a run then passes through the read data and output registers.
// Runs hold up to 64 packets. The payload memory needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none
module go_back_n_sender_core
    import gbn_pkg::*;
#(
    parameter int BUFFER_DEPTH  = 64,
    parameter int PAYLOAD_BYTES = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [159:0] s_tdata,   // seq_field, ack_field, sum_field, data_word
    input  wire logic [1:0]   s_tuser,   // opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // out_seq, out_sum, out_data
    output logic              m_tuser,   // is_resend
    output logic              m_tlast,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int QW = AW + $bits(job_t);

    logic          back_idle;
    logic          q_full, q_push, q_pop, q_valid;
    job_t          q_job_in, q_job_out;
    logic [AW-1:0] q_slot_in, q_slot_out;
    logic [QW-1:0] q_dout;
    logic          mem_we;
    logic [AW-1:0] mem_slot;
    logic [63:0]   mem_wdata;

    gbn_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .PAYLOAD_BYTES(PAYLOAD_BYTES),
        .AW           (AW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .back_idle(back_idle),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job_in),
        .q_slot   (q_slot_in),
        .mem_we   (mem_we),
        .mem_slot (mem_slot),
        .mem_wdata(mem_wdata)
    );

    gbn_queue #(
        .DW(QW)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .din    ({q_slot_in, q_job_in}),
        .full   (q_full),
        .pop    (q_pop),
        .dout   (q_dout),
        .valid  (q_valid)
    );

    assign q_job_out  = q_dout[$bits(job_t)-1:0];
    assign q_slot_out = q_dout[QW-1:$bits(job_t)];

    gbn_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .PAYLOAD_BYTES(PAYLOAD_BYTES),
        .AW           (AW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (q_job_out),
        .q_slot   (q_slot_out),
        .q_pop    (q_pop),
        .mem_we   (mem_we),
        .mem_slot (mem_slot),
        .mem_wdata(mem_wdata),
        .back_idle(back_idle),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_write_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> back_idle)
        else $error("payload written while a run is still being read");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("run queued into a full queue");

    a_run_length: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_job_in.count != '0) && (q_job_in.count <= CNT_W'(MAX_OUT)))
        else $error("run length out of range");

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import gbn_pkg::*;

    localparam int DEPTH = 64;
    localparam int AW = $clog2(DEPTH);
    localparam int N_OUT = 64;
    localparam logic [1:0] OP_RSVD = 2'd3;
    localparam int LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE = 20;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } chk_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [31:0] sum;
        logic [63:0] data;
        logic        fix_sum;
        chk_t        chk;
        logic [31:0] exp_seq;
        logic [31:0] exp_sum;
    } dir_row_t;

    typedef struct {
        logic [31:0] seq;
        logic [31:0] sum;
        logic [63:0] data;
        logic        resend;
        logic        last;
    } pkt_t;

    // fix_sum rows get a valid ACK checksum; CHK_ONE rows carry the packet typed in
    localparam dir_row_t DIR_TAB [27] = '{
        '{OP_TICK, 32'h0, 32'h0, 32'h0, 64'h0, 1'b0, CHK_NONE, 32'h0, 32'h0},
        '{OP_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
          1'b0, CHK_NONE, 32'h0, 32'h0},
        '{OP_ACK, 32'h0, 32'hFFFF_FFFF, 32'h0, 64'h0, 1'b1, CHK_NONE, 32'h0, 32'h0},
        '{OP_ACK, 32'h0, 32'h0, 32'h0, 64'h0, 1'b1, CHK_NONE, 32'h0, 32'h0},
        '{OP_MSG, 32'h0, 32'h0, 32'h0, 64'h0, 1'b0, CHK_ONE, 32'd0, 32'h0},
        '{OP_MSG, 32'h0, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, CHK_ONE,
          32'd1, 32'hFFFF_FFF9},
        '{OP_MSG, 32'h0, 32'h0, 32'h0, 64'h7F7F_7F7F_7F7F_7F7F, 1'b0, CHK_ONE,
          32'd2, 32'h0000_03FA},
        '{OP_MSG, 32'h0, 32'h0, 32'h0, 64'h8080_8080_8080_8080, 1'b0, CHK_ONE,
          32'd3, 32'hFFFF_FC03},
        '{OP_ACK, 32'h0, 32'h0, 32'h1, 64'h0, 1'b0, CHK_NONE, 32'h0, 32'h0},
        '{OP_ACK, 32'h0, 32'd4, 32'h0, 64'h0, 1'b1, CHK_NONE, 32'h0, 32'h0},
        '{OP_ACK, 32'hFFFF_FFFF, 32'd0, 32'h0, 64'h8000_0000_0000_00FF, 1'b1, CHK_NONE,
          32'h0, 32'h0},
        '{OP_ACK, 32'h1234_5678, 32'd0, 32'h0, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1, CHK_NONE,
          32'h0, 32'h0},
        '{OP_ACK, 32'h0, 32'd0, 32'h0, 64'hF0F0_F0F0_F0F0_F0F0, 1'b1, CHK_NONE,
          32'h0, 32'h0},
        '{OP_ACK, 32'h7FFF_FFFF, 32'd0, 32'h0, 64'h0, 1'b1, CHK_NONE, 32'h0, 32'h0},
        '{OP_ACK, 32'h8000_0000, 32'd0, 32'h0, 64'h55AA_55AA_55AA_55AA, 1'b1, CHK_MODEL,
          32'h0, 32'h0},
        '{OP_TICK, 32'h0, 32'h0, 32'h0, 64'h0, 1'b0, CHK_NONE, 32'h0, 32'h0},
        '{OP_TICK, 32'h0, 32'h0, 32'h0, 64'h0, 1'b0, CHK_MODEL, 32'h0, 32'h0},
        '{OP_MSG, 32'h0, 32'h0, 32'h0, 64'h0123_4567_89AB_CDEF, 1'b0, CHK_MODEL,
          32'h0, 32'h0},
        '{OP_MSG, 32'h0, 32'h0, 32'h0, 64'hFEDC_BA98_7654_3210, 1'b0, CHK_MODEL,
          32'h0, 32'h0},
        '{OP_MSG, 32'h0, 32'h0, 32'h0, 64'h5A5A_A5A5_0F0F_F0F0, 1'b0, CHK_MODEL,
          32'h0, 32'h0},
        '{OP_MSG, 32'h0, 32'h0, 32'h0, 64'h8001_7FFE_00FF_FF00, 1'b0, CHK_MODEL,
          32'h0, 32'h0},
        '{OP_MSG, 32'h0, 32'h0, 32'h0, 64'hDEAD_BEEF_0000_0001, 1'b0, CHK_MODEL,
          32'h0, 32'h0},
        '{OP_MSG, 32'h0, 32'h0, 32'h0, 64'h1122_3344_5566_7788, 1'b0, CHK_NONE,
          32'h0, 32'h0},
        '{OP_ACK, 32'h0, 32'd8, 32'h0, 64'h0, 1'b1, CHK_MODEL, 32'h0, 32'h0},
        '{OP_ACK, 32'h0, 32'd9, 32'h0, 64'h0, 1'b1, CHK_NONE, 32'h0, 32'h0},
        '{OP_TICK, 32'h0, 32'h0, 32'h0, 64'h0, 1'b0, CHK_NONE, 32'h0, 32'h0},
        '{OP_ACK, 32'h8000_0000, 32'd9, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, CHK_NONE,
          32'h0, 32'h0}
    };

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic [1:0]   s_tuser = OP_MSG;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = CFG_WINDOW;
    logic [31:0]  cfg_wdata = '0;

    // predictor copy of registers and state
    logic [6:0]  cfg_win = 7'd8;
    logic [15:0] cfg_tmo = 16'd15;
    logic [31:0] cfg_total = '0;
    logic [31:0] win_lo = '0;
    logic [31:0] send_ptr = '0;
    logic [31:0] fill_ptr = '0;
    logic [1:0]  dup_cnt = '0;
    logic        tmr_run = 1'b0;
    logic [15:0] tmr_left = '0;
    logic [63:0] pay_mem [DEPTH];

    pkt_t pkt_q [$];
    pkt_t burst [$];

    int src_idle = 0;
    int snk_stall = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;
    int errors = 0;
    int n_items = 0;
    int n_checked = 0;
    int n_resent = 0;
    int n_drop = 0;
    int n_fast = 0;
    int n_expire = 0;

    go_back_n_sender_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic logic [31:0] byte_sum(input logic [63:0] w);
        logic [31:0] s;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 32'(signed'(w[8*i +: 8]));
        end
        return s;
    endfunction

    function automatic int win_eff();
        if (cfg_win == 0) begin
            return 1;
        end
        if (cfg_win > N_OUT) begin
            return N_OUT;
        end
        return int'(cfg_win);
    endfunction

    function automatic void arm_timer();
        tmr_run = 1'b1;
        tmr_left = cfg_tmo;
    endfunction

    function automatic void put_pkt(input logic [31:0] sq, input logic rs);
        pkt_t p;
        if (burst.size() >= N_OUT) begin
            return;
        end
        p.seq = sq;
        p.data = pay_mem[sq[AW-1:0]];
        p.sum = sq + byte_sum(p.data);
        p.resend = rs;
        p.last = 1'b0;
        burst.push_back(p);
    endfunction

    function automatic void send_fresh();
        while (send_ptr != fill_ptr && (send_ptr - win_lo) < win_eff()
               && burst.size() < N_OUT) begin
            put_pkt(send_ptr, 1'b0);
            if (send_ptr == win_lo && !tmr_run) begin
                arm_timer();
            end
            send_ptr = send_ptr + 1;
        end
    endfunction

    function automatic void resend_window();
        logic [31:0] span;
        span = send_ptr - win_lo;
        for (int unsigned d = 0; d < span && burst.size() < N_OUT; d++) begin
            put_pkt(win_lo + d, 1'b1);
        end
    endfunction

    // updates the sender state for one accepted item; keep queues its packets
    task automatic predict_packets(input logic [1:0] op, input logic [31:0] sq,
                                   input logic [31:0] ak, input logic [31:0] sm,
                                   input logic [63:0] dw, input bit keep);
        logic [31:0] gap;
        logic [31:0] span;
        burst.delete();
        gap = ak - win_lo;
        span = send_ptr - win_lo;
        case (op)
            OP_MSG: begin
                if (fill_ptr - win_lo < DEPTH) begin
                    pay_mem[fill_ptr[AW-1:0]] = dw;
                    fill_ptr = fill_ptr + 1;
                    send_fresh();
                end else begin
                    n_drop++;
                end
            end
            OP_ACK: begin
                if (sq + ak + byte_sum(dw) == sm) begin
                    if (gap[31]) begin
                        if (win_lo != cfg_total) begin
                            if (dup_cnt == DUP_LIMIT) begin
                                resend_window();
                                dup_cnt = '0;
                                n_fast++;
                            end
                            dup_cnt = dup_cnt + 2'd1;
                        end
                    end else if (gap < span) begin
                        win_lo = ak + 1;
                        tmr_run = 1'b0;
                        if (win_lo == send_ptr) begin
                            send_fresh();
                        end else begin
                            arm_timer();
                        end
                    end
                end
            end
            OP_TICK: begin
                if (tmr_run) begin
                    if (tmr_left <= 1) begin
                        resend_window();
                        arm_timer();
                        n_expire++;
                    end else begin
                        tmr_left = tmr_left - 16'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (burst.size() > 0) begin
            burst[burst.size() - 1].last = 1'b1;
        end
        if (keep) begin
            foreach (burst[i]) begin
                pkt_q.push_back(burst[i]);
            end
        end
    endtask

    task automatic send_item(input logic [1:0] op, input logic [31:0] sq,
                             input logic [31:0] ak, input logic [31:0] sm,
                             input logic [63:0] dw, input bit keep);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {dw, sm, ak, sq};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_packets(op, sq, ak, sm, dw, keep);
        n_items++;
    endtask

    task automatic ack_item(input logic [31:0] ak);
        logic [31:0] sq;
        logic [63:0] dw;
        sq = $urandom;
        dw = {$urandom, $urandom};
        send_item(OP_ACK, sq, ak, sq + ak + byte_sum(dw), dw, 1'b1);
    endtask

    task automatic random_item();
        int pick;
        logic [31:0] span;
        pick = $urandom_range(99);
        span = send_ptr - win_lo;
        if (pick < 45 || (pick < 70 && span == 0)) begin
            send_item(OP_MSG, $urandom, $urandom, $urandom, {$urandom, $urandom}, 1'b1);
        end else if (pick < 70) begin
            ack_item(win_lo + $urandom_range(span - 1));
        end else if (pick < 80) begin
            ack_item(win_lo - 1 - $urandom_range(2));
        end else if (pick < 92) begin
            send_item(OP_TICK, $urandom, $urandom, $urandom, {$urandom, $urandom}, 1'b1);
        end else if (pick < 95) begin
            ack_item(send_ptr + $urandom_range(3));
        end else if (pick < 98) begin
            send_item(OP_ACK, $urandom, $urandom, $urandom, {$urandom, $urandom}, 1'b1);
        end else begin
            send_item(OP_RSVD, $urandom, $urandom, $urandom, {$urandom, $urandom}, 1'b1);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pkt_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [6:0] w, input logic [15:0] t,
                            input logic [31:0] tot);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_WINDOW;
        cfg_wdata <= {25'd0, w};
        @(posedge aclk);
        cfg_addr <= CFG_TIMEOUT;
        cfg_wdata <= {16'd0, t};
        @(posedge aclk);
        cfg_addr <= CFG_TOTAL;
        cfg_wdata <= tot;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_win = w;
        cfg_tmo = t;
        cfg_total = tot;
    endtask

    task automatic run_phase(input logic [6:0] w, input logic [15:0] t,
                             input logic [31:0] tot, input int src, input int snk,
                             input bit flood, input int n);
        settle();
        set_regs(w, t, tot);
        src_idle <= src;
        snk_stall <= snk;
        if (flood) begin
            // output held off while messages keep coming, then past a full buffer
            hold_reqs <= hold_reqs + 1;
            repeat (DEPTH + 3) begin
                send_item(OP_MSG, $urandom, $urandom, $urandom, {$urandom, $urandom}, 1'b1);
            end
        end
        repeat (n) random_item();
    endtask

    always @(posedge aclk) begin : rx
        pkt_t e;
        if (m_tvalid && m_tready) begin
            n_checked++;
            if (m_tuser) begin
                n_resent++;
            end
            if (pkt_q.size() == 0) begin
                $error("unexpected item: out_seq %h", m_tdata[31:0]);
                errors++;
            end else begin
                e = pkt_q.pop_front();
                if (m_tdata[31:0] !== e.seq) begin
                    $error("out_seq: expected %h, got %h", e.seq, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== e.sum) begin
                    $error("out_sum: expected %h, got %h", e.sum, m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[127:64] !== e.data) begin
                    $error("out_data: expected %h, got %h", e.data, m_tdata[127:64]);
                    errors++;
                end
                if (m_tuser !== e.resend) begin
                    $error("is_resend: expected %b, got %b", e.resend, m_tuser);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_of_run: expected %b, got %b", e.last, m_tlast);
                    errors++;
                end
            end
        end
        if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall);
        end
    end

    initial begin : main
        dir_row_t r;
        pkt_t p;
        logic [31:0] sm;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_regs(7'd8, 16'd2, 32'd0);

        for (int i = 0; i < $size(DIR_TAB); i++) begin
            r = DIR_TAB[i];
            sm = r.fix_sum ? r.seq + r.ack + byte_sum(r.data) : r.sum;
            send_item(r.op, r.seq, r.ack, sm, r.data, r.chk == CHK_MODEL);
            if (r.chk == CHK_ONE) begin
                p.seq = r.exp_seq;
                p.sum = r.exp_sum;
                p.data = r.data;
                p.resend = 1'b0;
                p.last = 1'b1;
                pkt_q.push_back(p);
            end
        end

        run_phase(7'd1,   16'd1,     32'd0,          0,  0,  1'b0, 14);
        run_phase(7'd64,  16'd3,     32'd5,          68, 0,  1'b1, 12);
        run_phase(7'd4,   16'd65535, 32'hFFFF_FFFF,  0,  68, 1'b0, 14);
        run_phase(7'd127, 16'd2,     32'd40,         10, 10, 1'b0, 14);
        run_phase(7'd0,   16'd5,     32'd0,          0,  0,  1'b0, 12);
        settle();

        $display("tb: %0d items sent over 6 register settings, %0d packets checked (%0d resent)",
                 n_items, n_checked, n_resent);
        $display("tb: %0d messages dropped on a full buffer, %0d fast resends, %0d expiries",
                 n_drop, n_fast, n_expire);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
